// ----- rtl/mahs_pkg.sv -----
// ----------------------------------------------------------------------------
// mahs_pkg
// Shared types and constants for the MPEG audio header sync block.
// ----------------------------------------------------------------------------
package mahs_pkg;

  // sync and header field constants
  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [3:0] SYNC_NIBBLE  = 4'hF;
  localparam logic [3:0] BITRATE_BAD  = 4'hF;
  localparam logic [1:0] RATE_BAD     = 2'h3;
  localparam logic [1:0] LAYER_III    = 2'h1;

  // parser phase
  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_SYNC2 = 3'd1,
    PH_HDR3  = 3'd2,
    PH_HDR4  = 3'd3,
    PH_CRC1  = 3'd4,
    PH_CRC2  = 3'd5
  } phase_t;

  // one decoded header
  typedef struct packed {
    logic        version_id;
    logic [1:0]  layer_code;
    logic        crc_present;
    logic [3:0]  bitrate_index;
    logic [1:0]  rate_index;
    logic        padding;
    logic [1:0]  channel_mode;
    logic [1:0]  mode_extension;
    logic [1:0]  emphasis;
    logic [2:0]  flag_bits;
    logic [15:0] crc_word;
    logic        layer_supported;
  } result_t;

  // result request from the parser to the output register
  typedef struct packed {
    logic    valid;
    result_t data;
  } res_req_t;

endpackage

// ----- rtl/mahs_byte_if.sv -----
// ----------------------------------------------------------------------------
// mahs_byte_if
// Byte stream channel: valid/ready with one stream byte.
// ----------------------------------------------------------------------------
interface mahs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/mahs_hdr_if.sv -----
// ----------------------------------------------------------------------------
// mahs_hdr_if
// Header result channel: valid/ready with the decoded header fields.
// ----------------------------------------------------------------------------
interface mahs_hdr_if;
  logic        valid;
  logic        ready;
  logic        version_id;
  logic [1:0]  layer_code;
  logic        crc_present;
  logic [3:0]  bitrate_index;
  logic [1:0]  rate_index;
  logic        padding;
  logic [1:0]  channel_mode;
  logic [1:0]  mode_extension;
  logic [1:0]  emphasis;
  logic [2:0]  flag_bits;
  logic [15:0] crc_word;
  logic        layer_supported;

  modport source (
    output valid, output version_id, output layer_code, output crc_present,
    output bitrate_index, output rate_index, output padding, output channel_mode,
    output mode_extension, output emphasis, output flag_bits, output crc_word,
    output layer_supported, input ready
  );
  modport sink (
    input valid, input version_id, input layer_code, input crc_present,
    input bitrate_index, input rate_index, input padding, input channel_mode,
    input mode_extension, input emphasis, input flag_bits, input crc_word,
    input layer_supported, output ready
  );
endinterface

// ----- rtl/mpeg_audio_header_sync.sv -----
// ----------------------------------------------------------------------------
// mpeg_audio_header_sync
// MPEG audio frame header sync: hunts for sync, splits and checks headers.
//
//   channel   dir  payload                         request
//   byte_ch   in   in_byte (8)                     one stream byte
//   hdr_ch    out  header fields, crc_word (16)    one decoded header
//
// one byte accepted per clock while the parser is not stalled; a byte passes
// the input register, the parser and the result register; the parser forms a
// result from the input register, and the result register takes it when out_free
// reset (rst, synchronous) clears phase, lock and both valid flags
// a stalled result holds the result register; the parser keeps taking bytes
// until a byte that completes a header meets a full result register
// ----------------------------------------------------------------------------
module mpeg_audio_header_sync (
  input  logic       clk,
  input  logic       rst,
  mahs_byte_if.sink  byte_ch,
  mahs_hdr_if.source hdr_ch
);

  mahs_pkg::res_req_t res_req;
  logic               out_free;

  // byte parser
  mahs_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .byte_ch  (byte_ch),
    .out_free (out_free),
    .res_req  (res_req)
  );

  // result register
  mahs_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_req  (res_req),
    .out_free (out_free),
    .hdr_ch   (hdr_ch)
  );

endmodule

// ----- rtl/mahs_parser.sv -----
// ----------------------------------------------------------------------------
// mahs_parser
// Input byte register, sync hunt, header collection, lock check and CRC
// collection; raises a result request when a header is complete.
// ----------------------------------------------------------------------------
module mahs_parser (
  input  logic               clk,
  input  logic               rst,
  mahs_byte_if.sink          byte_ch,
  input  logic               out_free,
  output mahs_pkg::res_req_t res_req
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // parser state
  mahs_pkg::phase_t phase, phase_next;
  logic [23:0] hdr, hdr_next;          // low three header bytes, top byte is 0xFF
  logic [7:0]  crc_hi, crc_hi_next;
  logic        locked_valid, locked_valid_next;
  logic [8:0]  locked_fields, locked_fields_next;

  logic        emit;
  logic [23:0] emit_hdr;
  logic [15:0] emit_crc;
  logic [23:0] h;
  logic [8:0]  key;
  logic        advance;

  // the byte moves on unless it completes a header and the output is full
  assign advance      = in_valid_q && (!emit || out_free);
  assign byte_ch.ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (byte_ch.ready) begin
      in_valid_q <= byte_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ch.ready && byte_ch.valid) begin
      in_byte_q <= byte_ch.in_byte;
    end
  end

  // candidate full header when the fourth byte arrives
  assign h   = {hdr[15:0], in_byte_q};
  assign key = {h[19], h[18:17], h[16], h[11:10], h[7:6], h[2]};

  // next state and result request
  always_comb begin
    phase_next         = phase;
    hdr_next           = hdr;
    crc_hi_next        = crc_hi;
    locked_valid_next  = locked_valid;
    locked_fields_next = locked_fields;
    emit               = 1'b0;
    emit_hdr           = h;
    emit_crc           = 16'h0000;
    case (phase)
      mahs_pkg::PH_SYNC2: begin
        if (in_byte_q[7:4] == mahs_pkg::SYNC_NIBBLE) begin
          hdr_next   = {hdr[15:0], in_byte_q};
          phase_next = mahs_pkg::PH_HDR3;
        end else begin
          phase_next = mahs_pkg::PH_HUNT;
        end
      end
      mahs_pkg::PH_HDR3: begin
        hdr_next   = {hdr[15:0], in_byte_q};
        phase_next = mahs_pkg::PH_HDR4;
      end
      mahs_pkg::PH_HDR4: begin
        hdr_next = h;
        if (h[15:12] == mahs_pkg::BITRATE_BAD || h[11:10] == mahs_pkg::RATE_BAD) begin
          phase_next = mahs_pkg::PH_HUNT;
        end else if (locked_valid && key != locked_fields) begin
          phase_next = mahs_pkg::PH_HUNT;
        end else begin
          locked_valid_next  = 1'b1;
          locked_fields_next = locked_valid ? locked_fields : key;
          if (!h[16]) begin
            phase_next = mahs_pkg::PH_CRC1;
          end else begin
            emit       = 1'b1;
            phase_next = mahs_pkg::PH_HUNT;
          end
        end
      end
      mahs_pkg::PH_CRC1: begin
        crc_hi_next = in_byte_q;
        phase_next  = mahs_pkg::PH_CRC2;
      end
      mahs_pkg::PH_CRC2: begin
        emit       = 1'b1;
        emit_hdr   = hdr;
        emit_crc   = {crc_hi, in_byte_q};
        phase_next = mahs_pkg::PH_HUNT;
      end
      default: begin
        hdr_next = {16'h0000, mahs_pkg::SYNC_BYTE};
        if (in_byte_q == mahs_pkg::SYNC_BYTE) begin
          phase_next = mahs_pkg::PH_SYNC2;
        end else begin
          phase_next = mahs_pkg::PH_HUNT;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mahs_pkg::PH_HUNT;
      locked_valid <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      locked_valid <= locked_valid_next;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    if (advance) begin
      hdr           <= hdr_next;
      crc_hi        <= crc_hi_next;
      locked_fields <= locked_fields_next;
    end
  end

  // field split of the finished header
  always_comb begin
    res_req.valid                = advance && emit;
    res_req.data.version_id      = emit_hdr[19];
    res_req.data.layer_code      = emit_hdr[18:17];
    res_req.data.crc_present     = !emit_hdr[16];
    res_req.data.bitrate_index   = emit_hdr[15:12];
    res_req.data.rate_index      = emit_hdr[11:10];
    res_req.data.padding         = emit_hdr[9];
    res_req.data.channel_mode    = emit_hdr[7:6];
    res_req.data.mode_extension  = emit_hdr[5:4];
    res_req.data.emphasis        = emit_hdr[1:0];
    res_req.data.flag_bits       = {emit_hdr[8], emit_hdr[3], emit_hdr[2]};
    res_req.data.crc_word        = emit_hdr[16] ? 16'h0000 : emit_crc;
    res_req.data.layer_supported = (emit_hdr[18:17] == mahs_pkg::LAYER_III);
  end

`ifndef ASSERT_OFF
  // results only come from the last header byte or the last CRC byte
  assert property (@(posedge clk) disable iff (rst)
    res_req.valid |-> (phase == mahs_pkg::PH_HDR4 || phase == mahs_pkg::PH_CRC2))
    else $error("result request outside header or CRC end");

  // after a result the parser is hunting again
  assert property (@(posedge clk) disable iff (rst)
    res_req.valid |=> phase == mahs_pkg::PH_HUNT)
    else $error("parser not hunting after result");

  // reserved indexes are never reported
  assert property (@(posedge clk) disable iff (rst)
    res_req.valid |-> (res_req.data.bitrate_index != mahs_pkg::BITRATE_BAD &&
                       res_req.data.rate_index != mahs_pkg::RATE_BAD))
    else $error("reserved index reported");

  // once locked, the lock stays
  assert property (@(posedge clk) disable iff (rst)
    locked_valid |=> locked_valid)
    else $error("lock lost");

  // a result request implies a lock is held or taken
  assert property (@(posedge clk) disable iff (rst)
    res_req.valid |=> locked_valid)
    else $error("result without lock");
`endif

endmodule

// ----- rtl/mahs_out_reg.sv -----
// ----------------------------------------------------------------------------
// mahs_out_reg
// Result register driving the header channel; holds a result until taken.
// ----------------------------------------------------------------------------
module mahs_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  mahs_pkg::res_req_t res_req,
  output logic               out_free,
  mahs_hdr_if.source         hdr_ch
);

  logic              valid;
  mahs_pkg::result_t data;

  // room when empty or being taken this cycle
  assign out_free = !valid || hdr_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= res_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_req.valid) begin
      data <= res_req.data;
    end
  end

  // drive the channel
  assign hdr_ch.valid           = valid;
  assign hdr_ch.version_id      = data.version_id;
  assign hdr_ch.layer_code      = data.layer_code;
  assign hdr_ch.crc_present     = data.crc_present;
  assign hdr_ch.bitrate_index   = data.bitrate_index;
  assign hdr_ch.rate_index      = data.rate_index;
  assign hdr_ch.padding         = data.padding;
  assign hdr_ch.channel_mode    = data.channel_mode;
  assign hdr_ch.mode_extension  = data.mode_extension;
  assign hdr_ch.emphasis        = data.emphasis;
  assign hdr_ch.flag_bits       = data.flag_bits;
  assign hdr_ch.crc_word        = data.crc_word;
  assign hdr_ch.layer_supported = data.layer_supported;

endmodule

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mpeg_audio_header_sync. A fixed run of stream bytes
// covers sync loss, reserved fields, the header lock and both ends of the
// free fields. It is followed by random frames, broken frames and noise.
// Every accepted byte goes through a local header parser. Its headers queue
// up and are compared field by field with each header request taken from
// the block. The sender works in bursts and the receiver stalls in patterns.
// ----------------------------------------------------------------------------
module tb;
  import mahs_pkg::*;

  localparam int RANDOM_BYTES = 820;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // how a stimulus row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_QUIET,
    CHK_TYPED
  } chk_t;

  typedef struct packed {
    logic [7:0] data;
    chk_t       chk;
    result_t    want;
  } dir_row_t;

  // locked header, all free fields at their lowest, crc word zero
  localparam result_t HDR_MIN = '{
    version_id: 1'b1, layer_code: 2'd1, crc_present: 1'b1, bitrate_index: 4'd0,
    rate_index: 2'd2, padding: 1'b0, channel_mode: 2'd3, mode_extension: 2'd0,
    emphasis: 2'd0, flag_bits: 3'b001, crc_word: 16'h0000, layer_supported: 1'b1
  };
  // same lock, all free fields at their highest, crc word all ones
  localparam result_t HDR_MAX = '{
    version_id: 1'b1, layer_code: 2'd1, crc_present: 1'b1, bitrate_index: 4'd14,
    rate_index: 2'd2, padding: 1'b1, channel_mode: 2'd3, mode_extension: 2'd3,
    emphasis: 2'd3, flag_bits: 3'b111, crc_word: 16'hFFFF, layer_supported: 1'b1
  };

  localparam int N_DIRECTED = 27;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // quiet byte after reset, then a sync byte and a failed second sync byte
    '{8'h00, CHK_QUIET, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hEF, CHK_QUIET, '0},
    // reserved bitrate index, dropped without locking
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFA, CHK_MODEL, '0},
    '{8'hF8, CHK_MODEL, '0},
    '{8'hC4, CHK_QUIET, '0},
    // reserved sample rate index, dropped without locking
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFA, CHK_MODEL, '0},
    '{8'h0C, CHK_MODEL, '0},
    '{8'hC4, CHK_QUIET, '0},
    // first good header takes the lock, crc follows
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFA, CHK_MODEL, '0},
    '{8'h08, CHK_MODEL, '0},
    '{8'hC4, CHK_MODEL, '0},
    '{8'h00, CHK_MODEL, '0},
    '{8'h00, CHK_TYPED, HDR_MIN},
    // free fields all set
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFA, CHK_MODEL, '0},
    '{8'hEB, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_MODEL, '0},
    '{8'hFF, CHK_TYPED, HDR_MAX},
    // reserved layer against the lock, dropped
    '{8'hFF, CHK_MODEL, '0},
    '{8'hF8, CHK_MODEL, '0},
    '{8'h08, CHK_MODEL, '0},
    '{8'hC4, CHK_QUIET, '0}
  };

  logic clk = 1'b0;
  logic rst;

  mahs_byte_if byte_ch ();
  mahs_hdr_if  hdr_ch ();

  mpeg_audio_header_sync dut (
    .clk    (clk),
    .rst    (rst),
    .byte_ch(byte_ch),
    .hdr_ch (hdr_ch)
  );

  always #5 clk = ~clk;

  // local parser state
  phase_t      parse_ph;
  logic [31:0] hdr_acc;
  logic [15:0] crc_acc;
  logic        lock_held;
  logic [8:0]  lock_key;

  result_t expected_hdrs[$];
  int      mismatches  = 0;
  int      burst_left  = 0;
  int      cycle_count = 0;
  int      rx_span     = 0;
  int      rx_mode     = 0;
  int      rx_tick     = 0;

  function automatic result_t split_header(logic [31:0] h, logic [15:0] crc);
    result_t r;
    r.version_id      = h[19];
    r.layer_code      = h[18:17];
    r.crc_present     = ~h[16];
    r.bitrate_index   = h[15:12];
    r.rate_index      = h[11:10];
    r.padding         = h[9];
    r.channel_mode    = h[7:6];
    r.mode_extension  = h[5:4];
    r.emphasis        = h[1:0];
    r.flag_bits       = {h[8], h[3], h[2]};
    r.crc_word        = h[16] ? 16'h0000 : crc;
    r.layer_supported = (h[18:17] == LAYER_III);
    return r;
  endfunction

  task automatic restart_hunt();
    parse_ph = PH_HUNT;
    hdr_acc  = '0;
    crc_acc  = '0;
  endtask

  // advance the parser by one stream byte; fires when a header completes
  task automatic parse_stream_byte(input logic [7:0] b, output bit fires,
                                   output result_t hdr);
    logic [31:0] h;
    logic [8:0]  key;
    fires = 1'b0;
    hdr   = '0;
    case (parse_ph)
      PH_SYNC2: begin
        if (b[7:4] != SYNC_NIBBLE) begin
          restart_hunt();
        end else begin
          hdr_acc  = {hdr_acc[23:0], b};
          parse_ph = PH_HDR3;
        end
      end
      PH_HDR3: begin
        hdr_acc  = {hdr_acc[23:0], b};
        parse_ph = PH_HDR4;
      end
      PH_HDR4: begin
        h       = {hdr_acc[23:0], b};
        hdr_acc = h;
        key     = {h[19], h[18:17], h[16], h[11:10], h[7:6], h[2]};
        if (h[15:12] == BITRATE_BAD || h[11:10] == RATE_BAD) begin
          restart_hunt();
        end else if (lock_held && key != lock_key) begin
          restart_hunt();
        end else begin
          lock_held = 1'b1;
          lock_key  = key;
          if (!h[16]) begin
            crc_acc  = '0;
            parse_ph = PH_CRC1;
          end else begin
            fires = 1'b1;
            hdr   = split_header(h, 16'h0000);
            restart_hunt();
          end
        end
      end
      PH_CRC1: begin
        crc_acc  = {8'h00, b};
        parse_ph = PH_CRC2;
      end
      PH_CRC2: begin
        crc_acc = {crc_acc[7:0], b};
        fires   = 1'b1;
        hdr     = split_header(hdr_acc, crc_acc);
        restart_hunt();
      end
      default: begin
        if (b == SYNC_BYTE) begin
          hdr_acc  = 32'h0000_00FF;
          parse_ph = PH_SYNC2;
        end else begin
          restart_hunt();
        end
      end
    endcase
  endtask

  // offer one byte in bursts, wait for the request to be taken, then predict
  task automatic send_byte(input logic [7:0] b, input chk_t chk, input result_t want);
    int      gap;
    bit      fires;
    result_t hdr;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.in_byte <= b;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    burst_left--;
    parse_stream_byte(b, fires, hdr);
    case (chk)
      CHK_TYPED: expected_hdrs.push_back(want);
      CHK_MODEL: if (fires) expected_hdrs.push_back(hdr);
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_header();
    result_t want;
    if (expected_hdrs.size() == 0) begin
      $error("header request with none expected");
      mismatches++;
    end else begin
      want = expected_hdrs.pop_front();
      check_field("version_id", 16'(want.version_id), 16'(hdr_ch.version_id));
      check_field("layer_code", 16'(want.layer_code), 16'(hdr_ch.layer_code));
      check_field("crc_present", 16'(want.crc_present), 16'(hdr_ch.crc_present));
      check_field("bitrate_index", 16'(want.bitrate_index), 16'(hdr_ch.bitrate_index));
      check_field("rate_index", 16'(want.rate_index), 16'(hdr_ch.rate_index));
      check_field("padding", 16'(want.padding), 16'(hdr_ch.padding));
      check_field("channel_mode", 16'(want.channel_mode), 16'(hdr_ch.channel_mode));
      check_field("mode_extension", 16'(want.mode_extension), 16'(hdr_ch.mode_extension));
      check_field("emphasis", 16'(want.emphasis), 16'(hdr_ch.emphasis));
      check_field("flag_bits", 16'(want.flag_bits), 16'(hdr_ch.flag_bits));
      check_field("crc_word", want.crc_word, hdr_ch.crc_word);
      check_field("layer_supported", 16'(want.layer_supported),
                  16'(hdr_ch.layer_supported));
    end
  endtask

  // receiver: check taken requests, then pick ready from the current stall mode
  always @(posedge clk) begin
    if (!rst && hdr_ch.valid === 1'b1 && hdr_ch.ready === 1'b1) begin
      check_header();
    end
    if (rx_span == 0) begin
      rx_span = $urandom_range(16, 96);
      rx_mode = $urandom_range(0, 3);
    end
    rx_span--;
    rx_tick++;
    case (rx_mode)
      0: hdr_ch.ready <= 1'b1;
      1: hdr_ch.ready <= 1'($urandom_range(0, 1));
      2: hdr_ch.ready <= ($urandom_range(0, 3) == 0);
      default: hdr_ch.ready <= rx_tick[3];
    endcase
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [7:0] frame[$];
    int         kind;
    int         sent;
    int         n;
    sent            = 0;
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.in_byte = 8'h00;
    hdr_ch.ready    = 1'b0;
    lock_held       = 1'b0;
    lock_key        = '0;
    restart_hunt();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed bytes
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].chk, DIRECTED[i].want);
    end

    // random frames, mostly well formed against the lock
    while (sent < RANDOM_BYTES) begin
      frame = {};
      kind  = $urandom_range(0, 99);
      if (kind < 55) begin
        frame.push_back(SYNC_BYTE);
        frame.push_back({SYNC_NIBBLE, lock_key[8], lock_key[7:6], lock_key[5]});
        frame.push_back({4'($urandom_range(0, 14)), lock_key[4:3],
                         2'($urandom_range(0, 3))});
        frame.push_back({lock_key[2:1], 3'($urandom_range(0, 7)), lock_key[0],
                         2'($urandom_range(0, 3))});
        if (!lock_key[5]) begin
          frame.push_back(8'($urandom_range(0, 255)));
          frame.push_back(8'($urandom_range(0, 255)));
        end
      end else if (kind < 65) begin
        // sync then anything; trailing bytes may land as crc
        frame.push_back(SYNC_BYTE);
        frame.push_back({SYNC_NIBBLE, 4'($urandom_range(0, 15))});
        repeat (4) frame.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
        // reserved bitrate or sample rate index
        frame.push_back(SYNC_BYTE);
        frame.push_back({SYNC_NIBBLE, lock_key[8], lock_key[7:6], lock_key[5]});
        if ($urandom_range(0, 1) == 1)
          frame.push_back({BITRATE_BAD, 4'($urandom_range(0, 15))});
        else
          frame.push_back({4'($urandom_range(0, 15)), RATE_BAD,
                           2'($urandom_range(0, 3))});
        frame.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        n = $urandom_range(1, 4);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 95) begin
        // lost sync or a header cut short
        frame.push_back(SYNC_BYTE);
        if ($urandom_range(0, 1) == 1) begin
          frame.push_back({4'($urandom_range(0, 14)), 4'($urandom_range(0, 15))});
        end else begin
          frame.push_back({SYNC_NIBBLE, lock_key[8], lock_key[7:6], lock_key[5]});
          frame.push_back(8'($urandom_range(0, 255)));
        end
      end else begin
        n = $urandom_range(2, 5);
        repeat (n) frame.push_back(SYNC_BYTE);
      end
      foreach (frame[k]) send_byte(frame[k], CHK_MODEL, '0);
      sent += frame.size();
    end
    byte_ch.valid <= 1'b0;

    // drain
    while (expected_hdrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_hdrs.size() == 0 && hdr_ch.valid !== 1'b1) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
